### hdl/capfd_pkg.sv
// Package for the coherent ASK/PSK/FSK demodulator core.
// Holds the mode and configuration index codes, the sine polynomial constants,
// the fixed field widths and a Q16 multiply helper. It depends on nothing else.
package capfd_pkg;

    typedef enum logic [1:0] {
        MODE_ASK = 2'd0,
        MODE_PSK = 2'd1,
        MODE_FSK = 2'd2
    } mode_t;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE            = 3'd0,
        CFG_SAMPLES_PER_BIT = 3'd1,
        CFG_CARRIER_STEP    = 3'd2,
        CFG_MARK_STEP       = 3'd3,
        CFG_SPACE_STEP      = 3'd4,
        CFG_ASK_THRESHOLD   = 3'd5
    } cfg_index_t;

    localparam int CFG_DATA_W  = 32;
    localparam int PHASE_W     = 32;
    localparam int INTEGRAL_W  = 32;
    localparam int SPB_W       = 12;
    localparam int THRESHOLD_W = 31;
    localparam int VOTES_W     = 12;
    localparam int OUT_TDATA_W = 16;

    localparam logic [1:0]             MODE_RESET      = 2'd0;
    localparam logic [SPB_W-1:0]       SPB_RESET       = 12'd572;
    localparam logic [PHASE_W-1:0]     CARRIER_RESET   = 32'd14998298;
    localparam logic [PHASE_W-1:0]     MARK_RESET      = 32'd22497447;
    localparam logic [PHASE_W-1:0]     SPACE_RESET     = 32'd29996596;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 31'd1171456;

    localparam int MIN_SAMPLES_PER_BIT = 2;

    // Sine polynomial datapath: all operands are unsigned Q16 values below 2^17.
    localparam int POLY_W = 17;
    localparam logic [POLY_W-1:0] SINE_C1 = 17'd102944;
    localparam logic [POLY_W-1:0] SINE_C3 = 17'd42048;
    localparam logic [POLY_W-1:0] SINE_C5 = 17'd4640;
    localparam int SINE_W = 16;
    localparam logic [SINE_W-1:0] SINE_MAX = 16'd16384;

    function automatic logic [POLY_W-1:0] mul_q16(input logic [POLY_W-1:0] a,
                                                  input logic [POLY_W-1:0] b);
        logic [2*POLY_W-1:0] p;
        p = {{POLY_W{1'b0}}, a} * {{POLY_W{1'b0}}, b};
        return p[POLY_W+15:16];
    endfunction

endpackage

### hdl/coherent_ask_psk_fsk_demodulator_core.sv
// Top level of the coherent ASK/PSK/FSK correlation demodulator core.
// Depends on capfd_pkg for codes, constants and the Q16 multiply helper.
//
// Usage: the input stream carries one received sample per transaction in
// s_tdata, with s_tuser set on the first sample of a frame. The result stream
// gives one transaction at the end of each bit period: m_tdata holds the
// decided bit and the number of samples that voted for bit zero. Registers
// are written through the cfg channel, which is always ready; write them only
// while no samples are in flight.
// Throughput is one sample per cycle while s_tready is high: the sine
// polynomial and mixers are a pipeline, and the integrate, vote and count
// loops close in single stages.
// Reset clears the configuration to its defaults, the phase accumulators,
// the integrals, the counters and all valid flags. When the receiver stalls,
// the result waits in the output register while samples keep flowing; the
// pipeline only halts when a second result reaches its last stage, and then
// s_tready drops until the waiting result is taken.
module coherent_ask_psk_fsk_demodulator_core #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16,
    parameter int COUNT_WIDTH     = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    // Fields from bit 0: frame_start.
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: bit_res, votes.
    output logic [capfd_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [capfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [capfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int X_SHIFT      = 18 - SINE_TABLE_BITS;
    localparam int PROD_W       = SAMPLE_WIDTH + 2;
    localparam int PW           = capfd_pkg::PHASE_W;
    localparam int IW           = capfd_pkg::INTEGRAL_W;
    localparam int XW           = capfd_pkg::POLY_W;
    localparam int SW           = capfd_pkg::SINE_W;
    localparam int VW           = COUNT_WIDTH + 3;
    localparam logic [QUARTER_BITS:0] QUARTER_ONE = {1'b1, {QUARTER_BITS{1'b0}}};

    // Configuration registers.
    capfd_pkg::mode_t                    mode_reg;
    logic [capfd_pkg::SPB_W-1:0]         spb_reg;
    logic [PW-1:0]                       carrier_step_reg;
    logic [PW-1:0]                       mark_step_reg;
    logic [PW-1:0]                       space_step_reg;
    logic [capfd_pkg::THRESHOLD_W-1:0]   threshold_reg;

    // Pipeline valid flags and side-band.
    logic [8:1]                          valid_reg;
    logic [7:1]                          fs_reg;
    logic signed [SAMPLE_WIDTH-1:0]      smp_reg [1:6];

    // Phase accumulators and per-channel pipeline payload (0 main, 1 second).
    logic [PW-1:0]                       phase_main_reg;
    logic [PW-1:0]                       phase_second_reg;
    logic [PW-1:0]                       ph1_reg   [2];
    logic [XW-1:0]                       x2_reg    [2];
    logic [XW-1:0]                       xx2_reg   [2];
    logic                                neg2_reg  [2];
    logic [XW-1:0]                       x3_reg    [2];
    logic [XW-1:0]                       xx3_reg   [2];
    logic [XW-1:0]                       t3_reg    [2];
    logic                                neg3_reg  [2];
    logic [XW-1:0]                       x4_reg    [2];
    logic [XW-1:0]                       t4_reg    [2];
    logic                                neg4_reg  [2];
    logic [XW-1:0]                       s5_reg    [2];
    logic                                neg5_reg  [2];
    logic signed [SW-1:0]                sine_reg  [2];
    logic signed [PROD_W-1:0]            prod_reg  [2];

    // Bit state.
    logic signed [IW-1:0]                integral_reg [2];
    logic [COUNT_WIDTH-1:0]              count_reg;
    logic [COUNT_WIDTH-1:0]              vote_count_reg;
    logic                                first8_reg;
    logic                                done8_reg;

    // Combinational next values.
    logic [XW-1:0]                       x2_next   [2];
    logic [XW-1:0]                       xx2_next  [2];
    logic                                neg2_next [2];
    logic [XW-1:0]                       t3_next   [2];
    logic [XW-1:0]                       t4_next   [2];
    logic [XW-1:0]                       s5_next   [2];
    logic signed [SW-1:0]                sine_next [2];
    logic signed [PROD_W-1:0]            prod_next [2];
    logic signed [IW-1:0]                integral_next [2];
    logic signed [SAMPLE_WIDTH+SW-1:0]   full_prod [2];
    logic [SINE_TABLE_BITS-1:0]          idx       [2];
    logic [QUARTER_BITS:0]               j_val     [2];
    logic [XW:0]                         rounded   [2];
    logic [SW-1:0]                       mag       [2];
    logic signed [IW:0]                  sum       [2];

    logic                                pipe_en;
    logic                                in_accept;
    logic                                is_fsk;
    logic [PW-1:0]                       step_main;
    logic [PW-1:0]                       phase_main_use;
    logic [PW-1:0]                       phase_second_use;
    logic signed [SAMPLE_WIDTH-1:0]      smp_in;
    logic [COUNT_WIDTH-1:0]              spb_eff;
    logic                                first8_next;
    logic [COUNT_WIDTH-1:0]              count_inc;
    logic                                done8_next;
    logic [COUNT_WIDTH-1:0]              count_next;
    logic                                vote;
    logic [COUNT_WIDTH-1:0]              vote_count_next;
    logic [VW-1:0]                       votes_x5;
    logic [VW-1:0]                       spb_x2;
    logic                                bit_res_next;

    assign pipe_en   = !(valid_reg[8] && done8_reg && m_tvalid && !m_tready);
    assign s_tready  = pipe_en;
    assign in_accept = s_tvalid && pipe_en;
    assign cfg_ready = 1'b1;

    always_comb begin
        case (mode_reg)
            capfd_pkg::MODE_ASK: is_fsk = 1'b0;
            capfd_pkg::MODE_PSK: is_fsk = 1'b0;
            default:             is_fsk = 1'b1;
        endcase
        step_main        = is_fsk ? mark_step_reg : carrier_step_reg;
        phase_main_use   = s_tuser[0] ? '0 : phase_main_reg;
        phase_second_use = s_tuser[0] ? '0 : phase_second_reg;
        smp_in           = s_tdata[SAMPLE_WIDTH-1:0];
    end

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            idx[ch]   = ph1_reg[ch][PW-1 -: SINE_TABLE_BITS];
            j_val[ch] = {1'b0, idx[ch][QUARTER_BITS-1:0]};
            if (idx[ch][QUARTER_BITS]) begin
                j_val[ch] = QUARTER_ONE - j_val[ch];
            end
            neg2_next[ch] = idx[ch][QUARTER_BITS+1];
            x2_next[ch]   = XW'(j_val[ch]) << X_SHIFT;
            xx2_next[ch]  = capfd_pkg::mul_q16(x2_next[ch], x2_next[ch]);

            t3_next[ch]   = capfd_pkg::mul_q16(capfd_pkg::SINE_C5, xx2_reg[ch]);
            t4_next[ch]   = capfd_pkg::mul_q16(capfd_pkg::SINE_C3 - t3_reg[ch], xx3_reg[ch]);
            s5_next[ch]   = capfd_pkg::mul_q16(capfd_pkg::SINE_C1 - t4_reg[ch], x4_reg[ch]);

            rounded[ch]   = {1'b0, s5_reg[ch]} + (XW+1)'(2);
            mag[ch]       = SW'(rounded[ch][XW:2]);
            if (mag[ch] > capfd_pkg::SINE_MAX) begin
                mag[ch] = capfd_pkg::SINE_MAX;
            end
            sine_next[ch] = neg5_reg[ch] ? -$signed(mag[ch]) : $signed(mag[ch]);

            full_prod[ch] = smp_reg[6] * sine_reg[ch];
            prod_next[ch] = full_prod[ch][SAMPLE_WIDTH+SW-1:SW-2];

            sum[ch] = {integral_reg[ch][IW-1], integral_reg[ch]}
                      + {{(IW+1-PROD_W){prod_reg[ch][PROD_W-1]}}, prod_reg[ch]};
            if (first8_next) begin
                integral_next[ch] = {{(IW-PROD_W){prod_reg[ch][PROD_W-1]}}, prod_reg[ch]};
            end else if (sum[ch][IW] != sum[ch][IW-1]) begin
                integral_next[ch] = sum[ch][IW] ? {1'b1, {(IW-1){1'b0}}}
                                                : {1'b0, {(IW-1){1'b1}}};
            end else begin
                integral_next[ch] = sum[ch][IW-1:0];
            end
        end
    end

    always_comb begin
        spb_eff = COUNT_WIDTH'(spb_reg);
        if (spb_eff < COUNT_WIDTH'(capfd_pkg::MIN_SAMPLES_PER_BIT)) begin
            spb_eff = COUNT_WIDTH'(capfd_pkg::MIN_SAMPLES_PER_BIT);
        end
        first8_next = fs_reg[7] || (count_reg == '0);
        count_inc   = (fs_reg[7] ? '0 : count_reg) + COUNT_WIDTH'(1);
        done8_next  = count_inc >= spb_eff;
        count_next  = done8_next ? '0 : count_inc;

        case (mode_reg)
            capfd_pkg::MODE_ASK: vote = integral_reg[0] >= $signed({1'b0, threshold_reg});
            capfd_pkg::MODE_PSK: vote = integral_reg[0] > 0;
            default:             vote = integral_reg[1] < integral_reg[0];
        endcase
        vote_count_next = (first8_reg ? '0 : vote_count_reg) + COUNT_WIDTH'(vote);
        votes_x5        = VW'({vote_count_next, 2'b00}) + VW'(vote_count_next);
        spb_x2          = VW'({spb_eff, 1'b0});
        bit_res_next    = !(votes_x5 > spb_x2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= capfd_pkg::mode_t'(capfd_pkg::MODE_RESET);
            spb_reg          <= capfd_pkg::SPB_RESET;
            carrier_step_reg <= capfd_pkg::CARRIER_RESET;
            mark_step_reg    <= capfd_pkg::MARK_RESET;
            space_step_reg   <= capfd_pkg::SPACE_RESET;
            threshold_reg    <= capfd_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                capfd_pkg::CFG_MODE:
                    mode_reg <= capfd_pkg::mode_t'(cfg_data[1:0]);
                capfd_pkg::CFG_SAMPLES_PER_BIT:
                    spb_reg <= cfg_data[capfd_pkg::SPB_W-1:0];
                capfd_pkg::CFG_CARRIER_STEP:
                    carrier_step_reg <= cfg_data[PW-1:0];
                capfd_pkg::CFG_MARK_STEP:
                    mark_step_reg <= cfg_data[PW-1:0];
                capfd_pkg::CFG_SPACE_STEP:
                    space_step_reg <= cfg_data[PW-1:0];
                capfd_pkg::CFG_ASK_THRESHOLD:
                    threshold_reg <= cfg_data[capfd_pkg::THRESHOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            phase_main_reg   <= '0;
            phase_second_reg <= '0;
            count_reg        <= '0;
            vote_count_reg   <= '0;
            integral_reg[0]  <= '0;
            integral_reg[1]  <= '0;
            first8_reg       <= 1'b0;
            done8_reg        <= 1'b0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[7:1], in_accept};
            if (in_accept) begin
                phase_main_reg   <= phase_main_use + step_main;
                phase_second_reg <= phase_second_use + space_step_reg;
            end
            if (valid_reg[7]) begin
                integral_reg[0] <= integral_next[0];
                integral_reg[1] <= integral_next[1];
                count_reg       <= count_next;
            end
            first8_reg <= first8_next;
            done8_reg  <= done8_next;
            if (valid_reg[8]) begin
                vote_count_reg <= vote_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ph1_reg[0] <= phase_main_use;
            ph1_reg[1] <= phase_second_use;
            fs_reg     <= {fs_reg[6:1], s_tuser[0]};
            smp_reg[1] <= smp_in;
            for (int k = 2; k <= 6; k++) begin
                smp_reg[k] <= smp_reg[k-1];
            end
            for (int ch = 0; ch < 2; ch++) begin
                x2_reg[ch]   <= x2_next[ch];
                xx2_reg[ch]  <= xx2_next[ch];
                neg2_reg[ch] <= neg2_next[ch];
                x3_reg[ch]   <= x2_reg[ch];
                xx3_reg[ch]  <= xx2_reg[ch];
                t3_reg[ch]   <= t3_next[ch];
                neg3_reg[ch] <= neg2_reg[ch];
                x4_reg[ch]   <= x3_reg[ch];
                t4_reg[ch]   <= t4_next[ch];
                neg4_reg[ch] <= neg3_reg[ch];
                s5_reg[ch]   <= s5_next[ch];
                neg5_reg[ch] <= neg4_reg[ch];
                sine_reg[ch] <= sine_next[ch];
                prod_reg[ch] <= prod_next[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (pipe_en && valid_reg[8] && done8_reg) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && valid_reg[8] && done8_reg) begin
            m_tdata <= capfd_pkg::OUT_TDATA_W'({capfd_pkg::VOTES_W'(vote_count_next),
                                                bit_res_next});
        end
    end

endmodule
